// ----- hdl/lmws_pkg.sv -----
`default_nettype none
package lmws_pkg;

  localparam int COORD_BITS = 32;
  localparam int XW         = ((COORD_BITS > 32) ? COORD_BITS : 32) + 4;

  localparam int SIDE_W  = 20;
  localparam int RANGE_W = 20;
  localparam int RATIO_W = 10;
  localparam int CFG_W   = 20;
  localparam int THR_W   = 22;
  localparam int T2_W    = 24;
  localparam int MOV_W   = 26;
  localparam int U_W     = 28;
  localparam int MUL_W   = 30;
  localparam int PROD_W  = 2 * MUL_W;

  localparam logic [1:0] REG_CUBE_SIDE    = 2'd0;
  localparam logic [1:0] REG_DETECT_RANGE = 2'd1;
  localparam logic [1:0] REG_MOVE_RATIO   = 2'd2;

  localparam logic [SIDE_W-1:0]  CUBE_SIDE_RST    = 20'd51200;
  localparam logic [RANGE_W-1:0] DETECT_RANGE_RST = 20'd76800;
  localparam logic [RATIO_W-1:0] MOVE_RATIO_RST   = 10'd384;

  // floor(x/20) by reciprocal on a biased, non-negative operand
  localparam logic [U_W-1:0]   RECIP_20 = 28'd214748364;
  localparam logic [U_W-1:0]   U_BIAS   = 28'd167772160;
  localparam logic [MOV_W-1:0] T1_BIAS  = 26'd8388608;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [XW-1:0]         wide_t;

  function automatic coord_t sat_coord(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = {{(XW - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[COORD_BITS-1:0];
    end else if (v < lo) begin
      return lo[COORD_BITS-1:0];
    end
    return v[COORD_BITS-1:0];
  endfunction

  // low 32 bits of the sign-extended coordinate
  function automatic logic [31:0] coord_lsw(input coord_t c);
    wide_t w;
    w = {{(XW - COORD_BITS){c[COORD_BITS-1]}}, c};
    return w[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/local_map_window_slider.sv -----
`default_nettype none
// Sliding local-map cube. The first position after reset places the cube around the
// sensor and produces no transaction. A later position is not accepted until the
// sequencer is back in idle, and waits while out_tready holds back a removal box. The
// sequencer makes three passes through one registered multiplier (threshold, range
// term, reciprocal divide by 20), then one axis per cycle through a shared compare unit
// and a shared pair of saturating adders, then one axis per cycle through the output
// register while out_tready does not hold back a box. Up to three removal boxes follow
// per position, in axis order, the final one flagged by out_tlast. The output register
// decouples the two sides, so the next position may be accepted while a box still waits.
// Configuration must be written only while idle; the block itself does not enforce this.
module local_map_window_slider
  import lmws_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // pos_x [31:0], pos_y [63:32], pos_z [95:64]
  input  wire logic [95:0]        in_tdata,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  // rm_min_x, rm_min_y, rm_min_z, rm_max_x, rm_max_y, rm_max_z, 32 bits each from bit 0
  output logic [191:0]            out_tdata,
  // moved_axis [1:0]
  output logic [1:0]              out_tuser,
  output logic                    out_tlast,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_wdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PLACE = 4'd1;
  localparam logic [3:0] S_THR   = 4'd2;
  localparam logic [3:0] S_T2    = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_FIX   = 4'd5;
  localparam logic [3:0] S_NEAR  = 4'd6;
  localparam logic [3:0] S_MOVE  = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0]             state_r, state_nxt;
  logic [1:0]             ax_r, ax_nxt;
  logic                   cube_valid_r, cube_valid_nxt;

  logic [SIDE_W-1:0]      cube_side_r;
  logic [RANGE_W-1:0]     detect_range_r;
  logic [RATIO_W-1:0]     move_ratio_r;

  logic signed [31:0]     pos_r [3];
  coord_t                 cube_low_r [3];
  coord_t                 cube_high_r [3];
  coord_t                 new_low_r [3];
  coord_t                 new_high_r [3];
  logic [2:0]             near_lo_r, near_hi_r;
  logic [THR_W-1:0]       thr_r;
  logic signed [T2_W-1:0] t2_r;
  logic signed [MOV_W-1:0] mov_r;

  logic [191:0]           out_data_r;
  logic [1:0]             out_axis_r;
  logic                   out_last_r;
  logic                   out_valid_r, out_valid_nxt;

  logic                   in_acc;
  logic                   out_free;

  // multiplier operands
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [10:0]              ratio_m;

  // divide-by-20 path
  logic signed [24:0]     a_diff;
  logic signed [29:0]     a_ext, a9, u_wide;
  logic [U_W-1:0]         u_val;
  logic [23:0]            q0;
  logic [28:0]            q20, rem;
  logic [24:0]            q;
  logic signed [MOV_W-1:0] t1, t2_ext, mov_val;

  // shared compare and adder unit
  wide_t                  pos_w, low_w, high_w, thr_w;
  wide_t                  d_lo, d_hi;
  logic                   near_lo, near_hi;
  wide_t                  base_lo, base_hi, add_lo, add_hi, half_w, madd, mov_w;
  coord_t                 sum_lo, sum_hi;

  // emission
  logic [2:0]             moved_v;
  logic                   cur_moved, later_moved, emit_adv;
  coord_t                 box_lo [3];
  coord_t                 box_hi [3];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign ratio_m = {1'b0, move_ratio_r} - 11'd256;

  always_comb begin
    case (state_r)
      S_THR: begin
        mul_a = $signed({{(MUL_W - RATIO_W){1'b0}}, move_ratio_r});
        mul_b = $signed({{(MUL_W - RANGE_W){1'b0}}, detect_range_r});
      end
      S_T2: begin
        mul_a = $signed({{(MUL_W - RANGE_W){1'b0}}, detect_range_r});
        mul_b = $signed({{(MUL_W - 11){ratio_m[10]}}, ratio_m});
      end
      default: begin
        mul_a = $signed({{(MUL_W - U_W){1'b0}}, u_val});
        mul_b = $signed({{(MUL_W - U_W){1'b0}}, RECIP_20});
      end
    endcase
  end

  lmws_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  always_comb begin
    a_diff  = $signed({5'b0, cube_side_r}) - $signed({2'b0, thr_r, 1'b0});
    a_ext   = {{5{a_diff[24]}}, a_diff};
    a9      = (a_ext <<< 3) + a_ext;
    u_wide  = a9 + $signed({2'b0, U_BIAS});
    u_val   = u_wide[U_W-1:0];
    q0      = prod[55:32];
    q20     = {1'b0, q0, 4'b0} + {3'b0, q0, 2'b0};
    rem     = {1'b0, u_val} - q20;
    // reciprocal estimate is at most one low
    q       = {1'b0, q0} + {24'b0, (rem >= 29'd20)};
    t1      = $signed({1'b0, q}) - $signed(T1_BIAS);
    t2_ext  = {{(MOV_W - T2_W){t2_r[T2_W-1]}}, t2_r};
    mov_val = (t1 > t2_ext) ? t1 : t2_ext;
  end

  always_comb begin
    pos_w   = {{(XW - 32){pos_r[ax_r][31]}}, pos_r[ax_r]};
    low_w   = {{(XW - COORD_BITS){cube_low_r[ax_r][COORD_BITS-1]}}, cube_low_r[ax_r]};
    high_w  = {{(XW - COORD_BITS){cube_high_r[ax_r][COORD_BITS-1]}}, cube_high_r[ax_r]};
    thr_w   = $signed({{(XW - THR_W){1'b0}}, thr_r});
    d_lo    = pos_w - low_w;
    d_hi    = pos_w - high_w;
    near_lo = (d_lo <= thr_w) && (d_lo >= -thr_w);
    near_hi = (d_hi <= thr_w) && (d_hi >= -thr_w);

    half_w  = $signed({{(XW - SIDE_W + 1){1'b0}}, cube_side_r[SIDE_W-1:1]});
    mov_w   = {{(XW - MOV_W){mov_r[MOV_W-1]}}, mov_r};
    // low face wins when both faces are near
    if (near_lo_r[ax_r]) begin
      madd = -mov_w;
    end else if (near_hi_r[ax_r]) begin
      madd = mov_w;
    end else begin
      madd = '0;
    end
    if (state_r == S_PLACE) begin
      base_lo = pos_w;
      base_hi = pos_w;
      add_lo  = -half_w;
      add_hi  = half_w;
    end else begin
      base_lo = low_w;
      base_hi = high_w;
      add_lo  = madd;
      add_hi  = madd;
    end
    sum_lo = sat_coord(base_lo + add_lo);
    sum_hi = sat_coord(base_hi + add_hi);
  end

  always_comb begin
    moved_v   = near_lo_r | near_hi_r;
    cur_moved = moved_v[ax_r];
    case (ax_r)
      2'd0:    later_moved = moved_v[1] || moved_v[2];
      2'd1:    later_moved = moved_v[2];
      default: later_moved = 1'b0;
    endcase
    emit_adv = !cur_moved || out_free;
    for (int j = 0; j < 3; j++) begin
      box_lo[j] = cube_low_r[j];
      box_hi[j] = cube_high_r[j];
    end
    if (near_lo_r[ax_r]) begin
      box_lo[ax_r] = new_high_r[ax_r];
    end else begin
      box_hi[ax_r] = new_low_r[ax_r];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    ax_nxt         = ax_r;
    cube_valid_nxt = cube_valid_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ax_nxt    = 2'd0;
          state_nxt = cube_valid_r ? S_THR : S_PLACE;
        end
      end
      S_PLACE: begin
        ax_nxt = ax_r + 2'd1;
        if (ax_r == 2'd2) begin
          cube_valid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_THR:  state_nxt = S_T2;
      S_T2:   state_nxt = S_DIV;
      S_DIV:  state_nxt = S_FIX;
      S_FIX: begin
        ax_nxt    = 2'd0;
        state_nxt = S_NEAR;
      end
      S_NEAR: begin
        ax_nxt = ax_r + 2'd1;
        if (ax_r == 2'd2) begin
          ax_nxt    = 2'd0;
          state_nxt = S_MOVE;
        end
      end
      S_MOVE: begin
        ax_nxt = ax_r + 2'd1;
        if (ax_r == 2'd2) begin
          ax_nxt    = 2'd0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (cur_moved && out_free) begin
          out_valid_nxt = 1'b1;
        end
        if (emit_adv) begin
          ax_nxt = ax_r + 2'd1;
          if (ax_r == 2'd2) begin
            ax_nxt    = 2'd0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      ax_r           <= 2'd0;
      cube_valid_r   <= 1'b0;
      out_valid_r    <= 1'b0;
      cube_side_r    <= CUBE_SIDE_RST;
      detect_range_r <= DETECT_RANGE_RST;
      move_ratio_r   <= MOVE_RATIO_RST;
    end else begin
      state_r      <= state_nxt;
      ax_r         <= ax_nxt;
      cube_valid_r <= cube_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_CUBE_SIDE:    cube_side_r    <= cfg_wdata[SIDE_W-1:0];
          REG_DETECT_RANGE: detect_range_r <= cfg_wdata[RANGE_W-1:0];
          REG_MOVE_RATIO:   move_ratio_r   <= cfg_wdata[RATIO_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pos_r[0] <= in_tdata[31:0];
      pos_r[1] <= in_tdata[63:32];
      pos_r[2] <= in_tdata[95:64];
    end
    if (state_r == S_PLACE) begin
      cube_low_r[ax_r]  <= sum_lo;
      cube_high_r[ax_r] <= sum_hi;
    end
    if (state_r == S_T2) begin
      thr_r <= prod[THR_W+7:8];
    end
    if (state_r == S_DIV) begin
      t2_r <= prod[T2_W+7:8];
    end
    if (state_r == S_FIX) begin
      mov_r <= mov_val;
    end
    if (state_r == S_NEAR) begin
      near_lo_r[ax_r] <= near_lo;
      near_hi_r[ax_r] <= near_hi;
    end
    if (state_r == S_MOVE) begin
      new_low_r[ax_r]  <= sum_lo;
      new_high_r[ax_r] <= sum_hi;
    end
    if (state_r == S_EMIT) begin
      if (cur_moved && out_free) begin
        out_data_r <= {coord_lsw(box_hi[2]), coord_lsw(box_hi[1]), coord_lsw(box_hi[0]),
                       coord_lsw(box_lo[2]), coord_lsw(box_lo[1]), coord_lsw(box_lo[0])};
        out_axis_r <= ax_r;
        out_last_r <= !later_moved;
      end
      // commit the moved cube once every box has been built from the old one
      if (emit_adv && ax_r == 2'd2) begin
        for (int j = 0; j < 3; j++) begin
          cube_low_r[j]  <= new_low_r[j];
          cube_high_r[j] <= new_high_r[j];
        end
      end
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_axis_r;
  assign out_tlast  = out_last_r;
  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

// ----- hdl/lmws_mul.sv -----
`default_nettype none
module lmws_mul
  import lmws_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [MUL_W-1:0]  op_a,
  input  wire logic signed [MUL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0]      prod
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule
`default_nettype wire
